// File: rtl/wjs_pkg.sv
// Package for the weighted job scheduling core.
// Shared types and constants; no dependencies.
package wjs_pkg;

    localparam int DUR_W    = 8;
    localparam int PROFIT_W = 16;
    localparam int TOTAL_W  = 20;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [PROFIT_W-1:0] profit;
        logic [DUR_W-1:0]    duration;
    } job_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RD_JOB,
        ST_RD_BEST,
        ST_CALC
    } wjs_state_t;

endpackage

// File: rtl/wjs_job_mem.sv
// Job store: duration and profit per day, one write and one read port.
// Depends on wjs_pkg for job_t.
module wjs_job_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  wjs_pkg::job_t    wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output wjs_pkg::job_t    rd_data
);

    wjs_pkg::job_t mem [DEPTH];
    wjs_pkg::job_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/wjs_best_mem.sv
// Store of best totals from each day, one write and one read port.
// Depends on wjs_pkg for the total width.
module wjs_best_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [wjs_pkg::TOTAL_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [wjs_pkg::TOTAL_W-1:0]  rd_data
);

    logic [wjs_pkg::TOTAL_W-1:0] mem [DEPTH];
    logic [wjs_pkg::TOTAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/weighted_job_schedule_max_profit_core.sv
// Weighted job scheduling core: loads a schedule, runs the backward pass.
// Depends on wjs_pkg, wjs_job_mem and wjs_best_mem.
//
// Input channel s_*: one item per day, taken at one per cycle while loading.
// s_tlast marks the final day and closes the schedule. Items past MAX_DAYS
// are dropped and reported through the overflow flag of the result.
// Output channel m_*: one result per schedule, best total and overflow flag.
// After the closing item the pass walks the stored days from last to first,
// in the states ST_RD_JOB, ST_RD_BEST and ST_CALC per day (job read,
// best-total read, compare and write back); m_tvalid comes from a register
// set in the ST_CALC state of the first day.
// While the pass runs s_tready is low. A waiting result sits in an output
// register: loading of the next schedule goes on under a stall, only its
// closing item is held until the result has been taken.
// Reset clears the day count, the overflow flag, the FSM and the output
// valid; the memories need no clearing, only written entries are read.
module weighted_job_schedule_max_profit_core #(
    parameter int MAX_DAYS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // duration [7:0], profit [23:8]
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // best_total [19:0], zero [23:20]
    output logic        m_tuser    // overflowed
);

    localparam int CW = $clog2(MAX_DAYS + 1);
    localparam int AW = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
    localparam int TW = CW + wjs_pkg::DUR_W + 1;
    localparam int SW = wjs_pkg::TOTAL_W + 1;

    wjs_pkg::wjs_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] day_reg, day_next;
    logic          ovf_reg, ovf_next;
    logic          out_valid_reg, out_valid_next;

    logic [wjs_pkg::TOTAL_W-1:0] skip_reg, skip_next;
    logic [wjs_pkg::TOTAL_W-1:0] out_data_reg, out_data_next;
    logic                        feas_reg, feas_next;
    logic                        sent_reg, sent_next;

    logic          s_accept;
    logic          stored;
    logic [CW-1:0] day_m1;

    logic                        job_wr_en;
    wjs_pkg::job_t               job_wr_data;
    logic                        job_rd_en;
    wjs_pkg::job_t               job_rd_data;

    logic                        best_wr_en;
    logic [wjs_pkg::TOTAL_W-1:0] best_wr_data;
    logic                        best_rd_en;
    logic [wjs_pkg::TOTAL_W-1:0] best_rd_data;

    logic [wjs_pkg::DUR_W-1:0]   len;
    logic [TW-1:0]               tgt;
    logic [TW-1:0]               tgt_m1;
    logic [TW-1:0]               n_p1;
    logic [SW-1:0]               take;
    logic [wjs_pkg::TOTAL_W-1:0] take_sat;
    logic [wjs_pkg::TOTAL_W-1:0] best_val;

    assign s_tready = (state_reg == wjs_pkg::ST_LOAD) && !(out_valid_reg && s_tlast);
    assign s_accept = s_tvalid && s_tready;
    assign stored   = (cnt_reg < CW'(MAX_DAYS));
    assign day_m1   = day_reg - CW'(1);

    assign job_wr_en            = s_accept && stored;
    assign job_wr_data.duration = s_tdata[7:0];
    assign job_wr_data.profit   = s_tdata[23:8];
    assign job_rd_en            = (state_reg == wjs_pkg::ST_RD_JOB);

    assign len    = (job_rd_data.duration == '0) ? wjs_pkg::DUR_W'(1) : job_rd_data.duration;
    assign tgt    = TW'(day_reg) + TW'(len);
    assign tgt_m1 = tgt - TW'(1);
    assign n_p1   = TW'(n_reg) + TW'(1);

    assign best_rd_en = (state_reg == wjs_pkg::ST_RD_BEST) && (tgt < n_p1);

    assign take     = SW'(job_rd_data.profit) + (sent_reg ? '0 : SW'(best_rd_data));
    assign take_sat = take[SW-1] ? wjs_pkg::TOTAL_MAX : take[wjs_pkg::TOTAL_W-1:0];
    assign best_val = (feas_reg && (take_sat > skip_reg)) ? take_sat : skip_reg;

    assign best_wr_en   = (state_reg == wjs_pkg::ST_CALC);
    assign best_wr_data = best_val;

    wjs_job_mem #(
        .DEPTH (MAX_DAYS),
        .AW    (AW)
    ) u_job_mem (
        .clk     (clk),
        .wr_en   (job_wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (job_wr_data),
        .rd_en   (job_rd_en),
        .rd_addr (day_m1[AW-1:0]),
        .rd_data (job_rd_data)
    );

    wjs_best_mem #(
        .DEPTH (MAX_DAYS),
        .AW    (AW)
    ) u_best_mem (
        .clk     (clk),
        .wr_en   (best_wr_en),
        .wr_addr (day_m1[AW-1:0]),
        .wr_data (best_wr_data),
        .rd_en   (best_rd_en),
        .rd_addr (tgt_m1[AW-1:0]),
        .rd_data (best_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        drop_next      = drop_reg;
        n_next         = n_reg;
        day_next       = day_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        skip_next      = skip_reg;
        out_data_next  = out_data_reg;
        feas_next      = feas_reg;
        sent_next      = sent_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            wjs_pkg::ST_LOAD:
            begin
                if (s_accept)
                begin
                    if (stored)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        n_next     = stored ? (cnt_reg + CW'(1)) : cnt_reg;
                        day_next   = n_next;
                        ovf_next   = drop_reg || !stored;
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        skip_next  = '0;
                        state_next = wjs_pkg::ST_RD_JOB;
                    end
                end
            end
            wjs_pkg::ST_RD_JOB:
            begin
                state_next = wjs_pkg::ST_RD_BEST;
            end
            wjs_pkg::ST_RD_BEST:
            begin
                feas_next  = (tgt <= n_p1);
                sent_next  = (tgt == n_p1);
                state_next = wjs_pkg::ST_CALC;
            end
            wjs_pkg::ST_CALC:
            begin
                skip_next = best_val;
                if (day_reg == CW'(1))
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = best_val;
                    state_next     = wjs_pkg::ST_LOAD;
                end
                else
                begin
                    day_next   = day_m1;
                    state_next = wjs_pkg::ST_RD_JOB;
                end
            end
            default:
            begin
                state_next = wjs_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wjs_pkg::ST_LOAD;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            n_reg         <= '0;
            day_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            drop_reg      <= drop_next;
            n_reg         <= n_next;
            day_reg       <= day_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skip_reg     <= skip_next;
        out_data_reg <= out_data_next;
        feas_reg     <= feas_next;
        sent_reg     <= sent_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24 - wjs_pkg::TOTAL_W){1'b0}}, out_data_reg};
    assign m_tuser  = ovf_reg;

`ifndef SYNTHESIS
    a_day_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != wjs_pkg::ST_LOAD) |-> (day_reg >= CW'(1) && day_reg <= n_reg))
        else $error("pass day index outside stored days");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_DAYS))
        else $error("day count beyond capacity");

    a_best_read_stored: assert property (@(posedge clk) disable iff (!rst_n)
        best_rd_en |-> (tgt > TW'(day_reg + CW'(1)) || len == wjs_pkg::DUR_W'(1))
                       && tgt_m1 < TW'(n_reg))
        else $error("best-total read outside written days");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wjs_pkg::ST_CALC && day_reg == CW'(1)) |-> !out_valid_reg)
        else $error("pass finished while previous result still pending");

    a_no_load_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wjs_pkg::ST_RD_JOB) |=> !job_wr_en && !$past(job_wr_en))
        else $error("job store written during pass");
`endif

endmodule

// File: bench/wjs_profit_checker.sv
// Scoreboard for the weighted job scheduling core: watches both streams,
// predicts each schedule's best total and overflow flag, compares results.
// Depends on wjs_pkg for field widths, the job layout and the total ceiling.
module wjs_profit_checker
    import wjs_pkg::*;
#(
    parameter int MAX_DAYS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // duration [7:0], profit [23:8]
    input  logic        s_tlast,   // is_last
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // best_total [19:0], zero [23:20]
    input  logic        m_tuser,   // overflowed
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               dropped;
    } outcome_t;

    logic [DUR_W-1:0]    day_len [MAX_DAYS];
    logic [PROFIT_W-1:0] day_pay [MAX_DAYS];
    int                  days_held;
    logic                overflow_seen;
    outcome_t            awaited_totals [$];
    int                  errors;

    // backward pass over the stored days
    function automatic logic [TOTAL_W-1:0] best_schedule_profit(input int n);
        logic [TOTAL_W-1:0] best [MAX_DAYS+2];
        logic [TOTAL_W:0]   take;
        int                 span;
        best[n+1] = '0;
        for (int d = n; d >= 1; d--)
        begin
            span = (day_len[d-1] == '0) ? 1 : int'(day_len[d-1]);
            best[d] = best[d+1];
            if (d + span <= n + 1)
            begin
                take = (TOTAL_W+1)'(day_pay[d-1]) + (TOTAL_W+1)'(best[d+span]);
                if (take > (TOTAL_W+1)'(TOTAL_MAX))
                    take = (TOTAL_W+1)'(TOTAL_MAX);
                if (take[TOTAL_W-1:0] > best[d])
                    best[d] = take[TOTAL_W-1:0];
            end
        end
        return (n >= 1) ? best[1] : '0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        job_t     job;
        outcome_t seen;
        outcome_t want;
        if (!rst_n)
        begin
            days_held = 0;
            overflow_seen = 1'b0;
            awaited_totals.delete();
            errors = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            // result side first: it always belongs to an older schedule
            if (m_tvalid && m_tready)
            begin
                seen.total = m_tdata[TOTAL_W-1:0];
                seen.dropped = m_tuser;
                if (awaited_totals.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%t: unexpected result total %0d overflow %0b",
                                 $realtime, seen.total, seen.dropped);
                end
                else
                begin
                    want = awaited_totals.pop_front();
                    if (seen != want || m_tdata[23:TOTAL_W] != '0)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%t: expected total %0d overflow %0b, got %0d %0b pad %h",
                                     $realtime, want.total, want.dropped, seen.total,
                                     seen.dropped, m_tdata[23:TOTAL_W]);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                job = s_tdata;
                if (days_held < MAX_DAYS)
                begin
                    day_len[days_held] = job.duration;
                    day_pay[days_held] = job.profit;
                    days_held++;
                end
                else
                    overflow_seen = 1'b1;
                if (s_tlast)
                begin
                    want.total = best_schedule_profit(days_held);
                    want.dropped = overflow_seen;
                    awaited_totals.push_back(want);
                    days_held = 0;
                    overflow_seen = 1'b0;
                end
            end
            mismatches <= errors;
            outstanding <= awaited_totals.size();
        end
    end

endmodule

// File: bench/testbench.sv
// Top of the bench for the weighted job scheduling core: clock, reset,
// schedule stimulus, result back-pressure and the verdict.
// Depends on wjs_pkg, the core and wjs_profit_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wjs_pkg::*;

    localparam int MAX_DAYS = 16;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // duration [7:0], profit [23:8]
    logic        s_tlast;   // is_last
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // best_total [19:0], zero [23:20]
    logic        m_tuser;   // overflowed

    int          mismatches;
    int          outstanding;
    logic        stall_req;
    bit          sender_burst;

    weighted_job_schedule_max_profit_core #(.MAX_DAYS(MAX_DAYS)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    wjs_profit_checker #(.MAX_DAYS(MAX_DAYS)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // result sink: random hold-off after each item unless in a burst, one long stall on request
    initial
    begin : sink
        int unsigned hold;
        bit          sink_burst;
        bit          stall_done;
        hold = 0;
        sink_burst = 1'b0;
        stall_done = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (m_tvalid && m_tready)
                begin
                    if ($urandom_range(0, 3) == 0)
                        sink_burst = ~sink_burst;
                    hold = sink_burst ? 0 : $urandom_range(0, 3);
                end
                else if (hold > 0)
                    hold--;
                if (stall_req && !stall_done)
                begin
                    hold = 300;
                    stall_done = 1'b1;
                end
                m_tready <= (hold == 0);
            end
        end
    end

    task automatic send_day(input logic [DUR_W-1:0] len, input logic [PROFIT_W-1:0] pay,
                            input logic last);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {pay, len};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_schedule(input int days);
        logic [DUR_W-1:0] len;
        for (int d = 1; d <= days; d++)
        begin
            len = ($urandom_range(0, 3) == 0) ? DUR_W'($urandom_range(0, 255))
                                              : DUR_W'($urandom_range(1, 4));
            send_day(len, PROFIT_W'($urandom()), d == days);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int sent;
        int schedules;
        int days;
        int pick;
        sent = 0;
        schedules = 0;
        sender_burst = 1'b0;
        stall_req = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero duration taken as one day, full profit
        send_day(8'd0, 16'hFFFF, 1'b1);
        // job longer than the schedule cannot be taken
        send_day(8'd255, 16'h1234, 1'b1);
        send_day(8'd1, 16'd0, 1'b1);
        // long job ending exactly at the end versus two short ones
        send_day(8'd3, 16'd100, 1'b0);
        send_day(8'd1, 16'd60, 1'b0);
        send_day(8'd1, 16'd50, 1'b1);
        // full store of maximum profits, closing item dropped
        for (int d = 0; d < MAX_DAYS; d++)
            send_day(8'd1, 16'hFFFF, 1'b0);
        send_day(8'd1, 16'd0, 1'b1);
        drain_results();

        while (sent < 1300)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                days = $urandom_range(MAX_DAYS + 1, MAX_DAYS + 4);
            else if (pick == 1)
                days = MAX_DAYS;
            else
                days = $urandom_range(1, MAX_DAYS - 1);
            sender_burst = ($urandom_range(0, 4) == 0);
            send_schedule(days);
            sent += days;
            schedules++;
            if (schedules == 2)
                stall_req <= 1'b1;
            if (schedules == 60)
                drain_results();
        end

        drain_results();
        repeat (3 * MAX_DAYS + 8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
